// File: sv/tmps_pkg.sv
// ----------------------------------------------------------------------------
// tmps_pkg
// Shared widths, types and helpers for the triangle minimum path sum block.
// ----------------------------------------------------------------------------
package tmps_pkg;

   // Row buffer geometry
   localparam int MAX_ROWS = 256;
   localparam int ROW_AW   = $clog2(MAX_ROWS);
   localparam int ROWS_W   = ROW_AW + 1;

   // Data widths
   localparam int VALUE_W  = 16;
   localparam int SUM_W    = 24;

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   // Per-request control flags, worked out at accept and carried to the update stage
   typedef struct packed {
      logic col_first;   // column 0 of its row
      logic right_edge;  // last column of its row
      logic has_above;   // a parent exists straight above
      logic final_row;   // this row is the last one of the triangle
      logic emit;        // last element of the triangle
   } cell_ctl_type;

   // Clamp a one-bit-grown sum to the signed sum range
   function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] s);
      logic signed [SUM_W-1:0] r;
      begin
         if (s[SUM_W] != s[SUM_W-1]) begin
            r = s[SUM_W] ? SUM_MIN : SUM_MAX;
         end else begin
            r = s[SUM_W-1:0];
         end
         return r;
      end
   endfunction

endpackage

// File: sv/tmps_ram.sv
// ----------------------------------------------------------------------------
// tmps_ram
// Generic single-write, single-read RAM with a registered read port.
// A read of the address written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module tmps_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/tmps_cell.sv
// ----------------------------------------------------------------------------
// tmps_cell
// Cell update: picks the cheaper parent, adds the element with saturation
// and folds the result into the last-row running minimum.
// ----------------------------------------------------------------------------
module tmps_cell (
   input  tmps_pkg::cell_ctl_type                  ctl,
   input  logic signed [tmps_pkg::VALUE_W-1:0]     value,
   input  logic signed [tmps_pkg::SUM_W-1:0]       above_raw,
   input  logic signed [tmps_pkg::SUM_W-1:0]       left_hold,
   input  logic signed [tmps_pkg::SUM_W-1:0]       run_min,
   output logic signed [tmps_pkg::SUM_W-1:0]       above,
   output logic signed [tmps_pkg::SUM_W-1:0]       cell_sum,
   output logic signed [tmps_pkg::SUM_W-1:0]       min_next
);

   logic signed [tmps_pkg::SUM_W-1:0] best;
   logic signed [tmps_pkg::SUM_W:0]   sum;

   // Parent straight above; none on the row's right edge
   assign above = ctl.has_above ? above_raw : '0;

   // Parent choice: the edges have a single parent
   always_comb begin
      if (ctl.col_first) begin
         best = above;
      end else if (ctl.right_edge) begin
         best = left_hold;
      end else begin
         best = (left_hold < above) ? left_hold : above;
      end
   end

   // Add and clamp
   assign sum = {{(tmps_pkg::SUM_W + 1 - tmps_pkg::VALUE_W){value[tmps_pkg::VALUE_W-1]}}, value}
              + {best[tmps_pkg::SUM_W-1], best};
   assign cell_sum = tmps_pkg::sat_sum(sum);

   // Running minimum over the last row, restarted at its first column
   assign min_next = (ctl.final_row && (ctl.col_first || cell_sum < run_min)) ? cell_sum
                                                                            : run_min;

endmodule

// File: sv/triangle_min_path_sum.sv
// ----------------------------------------------------------------------------
// triangle_min_path_sum
// Streams a number triangle in row-major order and returns its minimum
// top-to-bottom path sum after the last element.
// ----------------------------------------------------------------------------
// Elements enter one per request, top row first; csr_rows_in_use sets the row
// count (0 counts as 1, above 256 as 256). The user must write it only while
// idle; the block does not enforce this. One row of partial sums lives in a
// 256 x 24 RAM; each request reads its column in the accept cycle and the
// update stage writes the updated sum back, so the block takes one element
// per clock unless stalled. A read of the column being written in the same
// cycle is forwarded. Sums saturate to 24-bit signed. Input only stalls when
// the update stage holds a finished triangle and the result register is still
// waiting on rsp_ready.
module triangle_min_path_sum (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [tmps_pkg::ROWS_W-1:0]            csr_rows_in_use,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [tmps_pkg::VALUE_W-1:0]    req_cell_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [tmps_pkg::SUM_W-1:0]      rsp_min_sum
);

   localparam logic [tmps_pkg::ROWS_W-1:0] ROWS_CAP = tmps_pkg::ROWS_W'(tmps_pkg::MAX_ROWS);
   localparam logic [tmps_pkg::ROWS_W-1:0] ROWS_W_ONE = tmps_pkg::ROWS_W'(1);

   // Configuration and position counters
   logic [tmps_pkg::ROWS_W-1:0] rows_in_use_ff, rows_in_use_in;
   logic [tmps_pkg::ROW_AW-1:0] row_index_ff, row_index_in;
   logic [tmps_pkg::ROW_AW-1:0] col_index_ff, col_index_in;

   // Update stage
   logic                          b_valid_ff, b_valid_in;
   tmps_pkg::cell_ctl_type        b_ctl_ff, b_ctl_in;
   logic [tmps_pkg::ROW_AW-1:0]   b_col_ff;
   logic signed [tmps_pkg::VALUE_W-1:0] b_value_ff;
   logic                          fwd_ff, fwd_in;
   logic signed [tmps_pkg::SUM_W-1:0] fwd_data_ff;

   // Datapath state
   logic signed [tmps_pkg::SUM_W-1:0] left_hold_ff, left_hold_in;
   logic signed [tmps_pkg::SUM_W-1:0] run_min_ff, run_min_in;

   // Result register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [tmps_pkg::SUM_W-1:0] rsp_min_sum_ff;

   logic                              accept;
   logic                              b_stall;
   logic                              b_advance;
   logic [tmps_pkg::ROWS_W-1:0]       eff_rows;
   logic [tmps_pkg::ROWS_W-1:0]       last_row_w;
   logic [tmps_pkg::ROW_AW-1:0]       last_row;
   logic                              final_row;
   logic                              right_edge;
   logic [tmps_pkg::SUM_W-1:0]        ram_rd_data;
   logic signed [tmps_pkg::SUM_W-1:0] above_raw;
   logic signed [tmps_pkg::SUM_W-1:0] above;
   logic signed [tmps_pkg::SUM_W-1:0] cell_sum;
   logic signed [tmps_pkg::SUM_W-1:0] min_next;

   // Handshakes
   assign csr_ready = 1'b1;
   assign b_stall   = b_valid_ff && b_ctl_ff.emit && rsp_valid_ff && !rsp_ready;
   assign b_advance = b_valid_ff && !b_stall;
   assign req_ready = !b_stall;
   assign accept    = req_valid && req_ready;

   // Effective row count and position decode
   always_comb begin
      if (rows_in_use_ff == '0) begin
         eff_rows = ROWS_W_ONE;
      end else if (rows_in_use_ff > ROWS_CAP) begin
         eff_rows = ROWS_CAP;
      end else begin
         eff_rows = rows_in_use_ff;
      end
   end

   assign last_row_w = eff_rows - ROWS_W_ONE;
   assign last_row   = last_row_w[tmps_pkg::ROW_AW-1:0];
   assign final_row  = row_index_ff >= last_row;
   assign right_edge = col_index_ff >= row_index_ff;

   // Next-state logic
   always_comb begin
      rows_in_use_in = rows_in_use_ff;
      row_index_in   = row_index_ff;
      col_index_in   = col_index_ff;
      if (csr_valid && csr_ready) begin
         rows_in_use_in = csr_rows_in_use;
      end
      if (accept) begin
         if (right_edge) begin
            col_index_in = '0;
            row_index_in = final_row ? '0 : row_index_ff + 1'b1;
         end else begin
            col_index_in = col_index_ff + 1'b1;
         end
      end

      b_ctl_in.col_first  = (col_index_ff == '0);
      b_ctl_in.right_edge = right_edge;
      b_ctl_in.has_above  = !right_edge;
      b_ctl_in.final_row  = final_row;
      b_ctl_in.emit       = right_edge && final_row;

      b_valid_in = accept ? 1'b1 : (b_advance ? 1'b0 : b_valid_ff);

      // Same column written by the item leaving as the one read now
      fwd_in = b_advance && (b_col_ff == col_index_ff);

      left_hold_in = b_advance ? above : left_hold_ff;
      run_min_in   = b_advance ? min_next : run_min_ff;

      if (b_advance && b_ctl_ff.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_in_use_ff <= ROWS_W_ONE;
         row_index_ff   <= '0;
         col_index_ff   <= '0;
         b_valid_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         left_hold_ff   <= '0;
         run_min_ff     <= '0;
      end else begin
         rows_in_use_ff <= rows_in_use_in;
         row_index_ff   <= row_index_in;
         col_index_ff   <= col_index_in;
         b_valid_ff     <= b_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         left_hold_ff   <= left_hold_in;
         run_min_ff     <= run_min_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         b_ctl_ff    <= b_ctl_in;
         b_col_ff    <= col_index_ff;
         b_value_ff  <= req_cell_value;
         fwd_ff      <= fwd_in;
         fwd_data_ff <= cell_sum;
      end
      if (b_advance && b_ctl_ff.emit) begin
         rsp_min_sum_ff <= min_next;
      end
   end

   // Row buffer
   tmps_ram #(
      .WIDTH(tmps_pkg::SUM_W),
      .DEPTH(tmps_pkg::MAX_ROWS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (b_advance),
      .wr_addr (b_col_ff),
      .wr_data (cell_sum),
      .rd_en   (accept),
      .rd_addr (col_index_ff),
      .rd_data (ram_rd_data)
   );

   assign above_raw = fwd_ff ? fwd_data_ff : $signed(ram_rd_data);

   // Cell update
   tmps_cell u_cell (
      .ctl       (b_ctl_ff),
      .value     (b_value_ff),
      .above_raw (above_raw),
      .left_hold (left_hold_ff),
      .run_min   (run_min_ff),
      .above     (above),
      .cell_sum  (cell_sum),
      .min_next  (min_next)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_min_sum = rsp_min_sum_ff;

   // Checks
   a_col_within_row : assert property (@(posedge clock) disable iff (reset)
      col_index_ff <= row_index_ff)
      else $error("column index beyond row index");

   a_fwd_only_col0 : assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && fwd_ff) |-> (b_col_ff == '0))
      else $error("forwarding outside column 0");

   a_emit_shows_result : assert property (@(posedge clock) disable iff (reset)
      (b_advance && b_ctl_ff.emit) |=> rsp_valid_ff)
      else $error("finished triangle produced no response");

endmodule
